[src/uitp_pkg.sv]
// Shared types, constants and character helpers for the unsigned integer text parser.
// No dependencies; every other file of the block imports this package.
package uitp_pkg;

    // Default for the saturating position counter
    localparam longint unsigned MAX_LEN_DEFAULT = 64'd65535;

    // Field widths
    localparam int RADIX_W = 6;
    localparam int CHAR_W  = 8;
    localparam int VALUE_W = 64;
    localparam int STOP_W  = 16;
    localparam int DIGIT_W = 7;
    localparam int PHASE_W = 3;

    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
    localparam logic [RADIX_W-1:0] RADIX_AUTO  = 6'd0;
    localparam logic [RADIX_W-1:0] RADIX_ONE   = 6'd1;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_OCT   = 6'd8;
    localparam logic [RADIX_W-1:0] RADIX_DEC   = 6'd10;
    localparam logic [RADIX_W-1:0] RADIX_HEX   = 6'd16;

    // Parse phases
    localparam logic [PHASE_W-1:0] PH_DONE   = 3'd0;
    localparam logic [PHASE_W-1:0] PH_SPACE  = 3'd1;
    localparam logic [PHASE_W-1:0] PH_SIGNED = 3'd2;
    localparam logic [PHASE_W-1:0] PH_ZERO   = 3'd3;
    localparam logic [PHASE_W-1:0] PH_DIGITS = 3'd4;

    // Character codes
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UP_Z  = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_LO_A  = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LO_Z  = 8'h7A;
    localparam logic [CHAR_W-1:0] CH_X     = 8'h78;
    localparam logic [CHAR_W-1:0] LETTER_OFFSET = 8'd10;

    localparam logic [DIGIT_W-1:0] DIGIT_NONE = 7'd99;

    // One character as it leaves the input register
    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              first;
    } uitp_char_t;

    // One result item
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [STOP_W-1:0]  stop_position;
        logic               bad_radix;
    } uitp_result_t;

    // Digit value of a character in any base up to 36, DIGIT_NONE otherwise
    function automatic logic [DIGIT_W-1:0] digit_of(input logic [CHAR_W-1:0] c);
        logic [DIGIT_W-1:0] d;
        d = DIGIT_NONE;
        if (c >= CH_UP_A && c <= CH_UP_Z)
            d = DIGIT_W'(c - CH_UP_A + LETTER_OFFSET);
        else if (c >= CH_LO_A && c <= CH_LO_Z)
            d = DIGIT_W'(c - CH_LO_A + LETTER_OFFSET);
        else if (c >= CH_ZERO && c <= CH_NINE)
            d = DIGIT_W'(c - CH_ZERO);
        return d;
    endfunction

    // Blank, tab, newline, vertical tab, form feed or carriage return
    function automatic logic is_space(input logic [CHAR_W-1:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

endpackage

[src/uitp_ifs.sv]
// Handshake interfaces of the parser: character input, result output, radix write.
// Depends on uitp_pkg for field widths.
interface uitp_item_if;
    import uitp_pkg::*;
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] ch;
    logic              first;

    modport source (output valid, output ch, output first, input ready);
    modport sink   (input valid, input ch, input first, output ready);
endinterface

interface uitp_result_if;
    import uitp_pkg::*;
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;
    logic [STOP_W-1:0]  stop_position;
    logic               bad_radix;

    modport source (output valid, output value, output stop_position, output bad_radix,
                    input ready);
    modport sink   (input valid, input value, input stop_position, input bad_radix,
                    output ready);
endinterface

interface uitp_cfg_if;
    import uitp_pkg::*;
    logic               valid;
    logic               ready;
    logic [RADIX_W-1:0] radix;

    modport source (output valid, output radix, input ready);
    modport sink   (input valid, input radix, output ready);
endinterface

[src/uitp_in_reg.sv]
// Input register: captures one character transaction and holds it until the core takes it.
// Depends on uitp_pkg and uitp_item_if.
module uitp_in_reg
(
    input  logic                clk,
    input  logic                rst_n,
    uitp_item_if.sink           item,
    input  logic                take,
    output logic                valid,
    output uitp_pkg::uitp_char_t chr
);
    import uitp_pkg::*;

    logic       valid_reg;
    uitp_char_t chr_reg;

    // Accept when empty or when the held character leaves this cycle
    assign item.ready = !valid_reg || take;
    assign valid      = valid_reg;
    assign chr        = chr_reg;

    // Track occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (item.valid && item.ready)
            valid_reg <= 1'b1;
        else if (take)
            valid_reg <= 1'b0;
    end

    // Load the payload on each transaction
    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            chr_reg.ch    <= item.ch;
            chr_reg.first <= item.first;
        end
    end
endmodule

[src/uitp_core.sv]
// Parse core: holds the per-string state and works one character per cycle while take is high.
// Depends on uitp_pkg (phases, character helpers, result type).
module uitp_core
#(
    parameter longint unsigned MAX_LEN = uitp_pkg::MAX_LEN_DEFAULT
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          take,
    input  uitp_pkg::uitp_char_t          chr,
    input  logic [uitp_pkg::RADIX_W-1:0]  radix,
    output logic                          emit,
    output uitp_pkg::uitp_result_t        res
);
    import uitp_pkg::*;

    localparam int POS_W = $clog2(MAX_LEN + 1);
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_LEN);
    localparam logic [VALUE_W-1:0] ALL_ONES = '1;
    localparam int PROD_W = VALUE_W + RADIX_W;

    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [VALUE_W-1:0] acc_reg, acc_next;
    logic               neg_reg, neg_next;
    logic [RADIX_W-1:0] base_reg, base_next;
    logic [POS_W-1:0]   pos_reg, pos_next;

    logic [PHASE_W-1:0] ph;
    logic [VALUE_W-1:0] acc_eff;
    logic [VALUE_W-1:0] acc_op;
    logic               neg_eff;
    logic [RADIX_W-1:0] base_eff;
    logic [RADIX_W-1:0] b_sel;
    logic [POS_W-1:0]   pos_eff;
    logic [POS_W+STOP_W-1:0] pos_ext;
    logic [DIGIT_W-1:0] dig;
    logic [PROD_W-1:0]  mac;
    logic               bad;
    logic               stop;
    logic               prefix;
    logic               do_digit;
    logic               pos_step;

    // Digit value of the character at hand
    assign dig     = digit_of(chr.ch);
    assign pos_ext = {{STOP_W{1'b0}}, pos_eff};

    // Next state and result for the character at hand
    always_comb
    begin
        ph       = phase_reg;
        acc_eff  = acc_reg;
        neg_eff  = neg_reg;
        base_eff = base_reg;
        pos_eff  = pos_reg;
        bad      = 1'b0;

        // Restart on the first character of a string, latching the radix
        if (chr.first)
        begin
            pos_eff = '0;
            acc_eff = '0;
            neg_eff = 1'b0;
            if (radix == RADIX_ONE || radix > RADIX_MAX)
            begin
                base_eff = RADIX_AUTO;
                ph       = PH_DONE;
                bad      = 1'b1;
            end
            else
            begin
                base_eff = radix;
                ph       = PH_SPACE;
            end
        end

        acc_op     = (ph == PH_ZERO) ? '0 : acc_eff;
        phase_next = ph;
        acc_next   = acc_eff;
        neg_next   = neg_eff;
        base_next  = base_eff;
        b_sel      = base_eff;
        pos_step   = 1'b0;
        prefix     = 1'b0;
        do_digit   = 1'b0;
        stop       = 1'b0;

        case (ph)
            PH_SPACE:
            begin
                if (is_space(chr.ch))
                    pos_step = 1'b1;
                else if (chr.ch == CH_PLUS || chr.ch == CH_MINUS)
                begin
                    neg_next   = (chr.ch == CH_MINUS);
                    phase_next = PH_SIGNED;
                    pos_step   = 1'b1;
                end
                else
                    prefix = 1'b1;
            end
            PH_SIGNED:
                prefix = 1'b1;
            PH_ZERO:
            begin
                acc_next = '0;
                if (chr.ch == CH_X)
                begin
                    base_next  = RADIX_HEX;
                    phase_next = PH_DIGITS;
                    pos_step   = 1'b1;
                end
                else
                begin
                    b_sel    = (base_eff == RADIX_AUTO) ? RADIX_OCT : base_eff;
                    do_digit = 1'b1;
                end
            end
            PH_DIGITS:
                do_digit = 1'b1;
            default:
                ;
        endcase

        // Leading zero: wait for a possible x before treating it as a digit
        if (prefix)
        begin
            if (chr.ch == CH_ZERO && (base_eff == RADIX_AUTO || base_eff == RADIX_HEX))
            begin
                phase_next = PH_ZERO;
                pos_step   = 1'b1;
            end
            else
            begin
                b_sel    = (base_eff == RADIX_AUTO) ? RADIX_DEC : base_eff;
                do_digit = 1'b1;
            end
        end

        // One multiply-add of the accumulator by the base
        mac = PROD_W'(acc_op) * PROD_W'(b_sel) + PROD_W'(dig);

        // Accumulate a digit of the base, or stop on anything else
        if (do_digit)
        begin
            base_next = b_sel;
            if (b_sel < RADIX_MIN || dig >= DIGIT_W'(b_sel))
            begin
                stop       = 1'b1;
                phase_next = PH_DONE;
            end
            else
            begin
                acc_next   = (mac[PROD_W-1:VALUE_W] != '0) ? ALL_ONES : mac[VALUE_W-1:0];
                phase_next = PH_DIGITS;
                pos_step   = 1'b1;
            end
        end

        pos_next = (pos_step && pos_eff < POS_MAX) ? pos_eff + 1'b1 : pos_eff;

        // Build the result
        if (bad)
        begin
            res.value         = '0;
            res.stop_position = '0;
            res.bad_radix     = 1'b1;
        end
        else
        begin
            res.value         = (neg_eff && acc_op != ALL_ONES) ? (VALUE_W'(0) - acc_op) : acc_op;
            res.stop_position = pos_ext[STOP_W-1:0];
            res.bad_radix     = 1'b0;
        end
    end

    assign emit = take && (bad || stop);

    // Advance the parse state on each character taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_DONE;
            acc_reg   <= '0;
            neg_reg   <= 1'b0;
            base_reg  <= RADIX_AUTO;
            pos_reg   <= '0;
        end
        else if (take)
        begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            neg_reg   <= neg_next;
            base_reg  <= base_next;
            pos_reg   <= pos_next;
        end
    end
endmodule

[src/uitp_out_reg.sv]
// Output register: holds one result transaction until the sink takes it.
// Depends on uitp_pkg and uitp_result_if.
module uitp_out_reg
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load,
    input  uitp_pkg::uitp_result_t res,
    output logic                   can_accept,
    uitp_result_if.source          result
);
    import uitp_pkg::*;

    logic         valid_reg;
    uitp_result_t res_reg;

    // Free when empty or when the held result leaves this cycle
    assign can_accept           = !valid_reg || result.ready;
    assign result.valid         = valid_reg;
    assign result.value         = res_reg.value;
    assign result.stop_position = res_reg.stop_position;
    assign result.bad_radix     = res_reg.bad_radix;

    // Track occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load)
            valid_reg <= 1'b1;
        else if (result.ready)
            valid_reg <= 1'b0;
    end

    // Load the payload
    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= res;
    end
endmodule

[src/unsigned_integer_text_parser_top.sv]
// Top level of the unsigned integer text parser: radix register and the three stages.
// Depends on uitp_pkg, the interfaces in uitp_ifs.sv, uitp_in_reg, uitp_core, uitp_out_reg.
//
// Converts a character stream into unsigned 64-bit values in the manner of strtoul. The block
// accepts one character per clock cycle, continuously, as long as the result side is not
// stalled; the parse core performs a single multiply-add of the 64-bit accumulator by the base
// per character. A character that stops the scan is held in the input register, and the parse
// core loads its result into the output register as soon as that register has room. The radix
// written through cfg is sampled on the first character of each string, so a write takes
// effect from the next string; cfg is always ready. Characters with first low outside a string
// are dropped, and a string that never meets a non-digit produces no result.
module unsigned_integer_text_parser_top
#(
    parameter longint unsigned MAX_LEN = uitp_pkg::MAX_LEN_DEFAULT
)
(
    input  logic           clk,
    input  logic           rst_n,
    uitp_item_if.sink      item,
    uitp_result_if.source  result,
    uitp_cfg_if.sink       cfg
);
    import uitp_pkg::*;

    logic [RADIX_W-1:0] radix_reg;
    logic               chr_valid;
    uitp_char_t         chr;
    logic               take;
    logic               can_accept;
    logic               emit;
    uitp_result_t       res;

    // Hold the configured radix
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            radix_reg <= RADIX_RESET;
        else if (cfg.valid && cfg.ready)
            radix_reg <= cfg.radix;
    end

    // Advance a character whenever the output stage has room
    assign take = chr_valid && can_accept;

    uitp_in_reg u_in_reg
    (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item),
        .take  (take),
        .valid (chr_valid),
        .chr   (chr)
    );

    uitp_core #(.MAX_LEN(MAX_LEN)) u_core
    (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (take),
        .chr   (chr),
        .radix (radix_reg),
        .emit  (emit),
        .res   (res)
    );

    uitp_out_reg u_out_reg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (emit),
        .res        (res),
        .can_accept (can_accept),
        .result     (result)
    );
endmodule

[src/uitp_checker.sv]
// Port-level checks for the unsigned integer text parser, bound to the top level.
// Depends on uitp_pkg for field widths.
module uitp_checker
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          item_valid,
    input logic                          item_ready,
    input logic                          result_valid,
    input logic                          result_ready,
    input logic [uitp_pkg::VALUE_W-1:0]  result_value,
    input logic [uitp_pkg::STOP_W-1:0]   result_stop_position,
    input logic                          result_bad_radix,
    input logic                          cfg_ready
);
    import uitp_pkg::*;

    // An invalid base reports zero at position zero
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_bad_radix |-> result_value == '0 && result_stop_position == '0)
        else $error("bad radix result carries nonzero value or position");

    // A rising result valid must follow an accepted character transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(item_valid && item_ready, 2))
        else $error("result without a matching character transaction");

    // The radix register takes every write
    assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
        else $error("configuration port not ready");

    // A stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result_value)
            && $stable(result_stop_position) && $stable(result_bad_radix))
        else $error("stalled result changed");
endmodule

bind unsigned_integer_text_parser_top uitp_checker u_uitp_checker
(
    .clk                  (clk),
    .rst_n                (rst_n),
    .item_valid           (item.valid),
    .item_ready           (item.ready),
    .result_valid         (result.valid),
    .result_ready         (result.ready),
    .result_value         (result.value),
    .result_stop_position (result.stop_position),
    .result_bad_radix     (result.bad_radix),
    .cfg_ready            (cfg.ready)
);

[dv/tb_unsigned_integer_text_parser_top.sv]
// Self-checking testbench for unsigned_integer_text_parser_top: a scoreboard class predicts
// every result from the accepted characters and radix writes. Depends on uitp_pkg, uitp_ifs.sv, the DUT.
`timescale 1ns / 1ps

module tb_unsigned_integer_text_parser_top;
    import uitp_pkg::*;

    localparam int          CLK_HALF     = 5;
    localparam int          RESET_CYCLES = 11;
    localparam int          MAX_GAP      = 16;
    localparam int          SETTLE_LAT   = 6;
    localparam int          HOLD_CYCLES  = 400;
    localparam int          RANDOM_ITEMS = 360;
    localparam int          LONG_DIGITS  = 40;
    localparam int unsigned CYCLE_LIMIT  = 600000;
    localparam logic [VALUE_W-1:0] ALL_ONES = {VALUE_W{1'b1}};

    logic clk = 1'b0;
    logic rst_n;

    uitp_item_if   item_if ();
    uitp_result_if res_if ();
    uitp_cfg_if    cfg_if ();

    unsigned_integer_text_parser_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_if),
        .result (res_if),
        .cfg    (cfg_if)
    );

    // Value of a character as a digit in bases up to 36; 99 marks a non-digit
    function automatic int unsigned char_value(input logic [CHAR_W-1:0] c);
        if (c >= CH_UP_A && c <= CH_UP_Z)
            return c - CH_UP_A + 10;
        if (c >= CH_LO_A && c <= CH_LO_Z)
            return c - CH_LO_A + 10;
        if (c >= CH_ZERO && c <= CH_NINE)
            return c - CH_ZERO;
        return 99;
    endfunction

    // Parse-state predictor and store of the results still to come
    class strtoul_scoreboard;
        logic [RADIX_W-1:0] radix_reg;
        logic [PHASE_W-1:0] phase;
        logic [VALUE_W-1:0] acc;
        bit                 neg;
        logic [RADIX_W-1:0] base;
        longint unsigned    pos;
        uitp_result_t       due_results[$];
        int unsigned        n_fail;
        int unsigned        n_checked;

        function new();
            radix_reg = RADIX_RESET;
            phase     = PH_DONE;
            acc       = '0;
            neg       = 1'b0;
            base      = '0;
            pos       = 0;
            n_fail    = 0;
            n_checked = 0;
        endfunction

        function void set_radix(input logic [RADIX_W-1:0] r);
            radix_reg = r;
        endfunction

        function bit busy();
            return phase != PH_DONE;
        endfunction

        function int unsigned pending();
            return due_results.size();
        endfunction

        function bit is_blank(input logic [CHAR_W-1:0] c);
            return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
        endfunction

        // Accumulate one digit, or stop the scan and build the result
        function bit digit_step(input logic [CHAR_W-1:0] c, output uitp_result_t r);
            int unsigned        d;
            logic [VALUE_W-1:0] b;
            logic [VALUE_W-1:0] v;
            logic [VALUE_W-1:0] p;
            logic [VALUE_W:0]   s;
            d = char_value(c);
            b = VALUE_W'(base);
            r = '0;
            if (base < RADIX_MIN || d >= b) begin
                v = acc;
                if (neg && v != ALL_ONES)
                    v = 64'd0 - v;
                r.value         = v;
                r.stop_position = pos[STOP_W-1:0];
                r.bad_radix     = 1'b0;
                phase = PH_DONE;
                return 1'b1;
            end
            if (acc == ALL_ONES || acc > ALL_ONES / b) begin
                acc = ALL_ONES;
            end else begin
                p   = acc * b;
                s   = {1'b0, p} + (VALUE_W + 1)'(d);
                acc = s[VALUE_W] ? ALL_ONES : s[VALUE_W-1:0];
            end
            phase = PH_DIGITS;
            return 1'b0;
        endfunction

        // Note one accepted character and queue the result it causes, if any
        function void note_char(input logic [CHAR_W-1:0] c, input logic f);
            uitp_result_t r;
            bit           stopped;
            stopped = 1'b0;
            if (f) begin
                pos = 0;
                acc = '0;
                neg = 1'b0;
                if (radix_reg == RADIX_ONE || radix_reg > RADIX_MAX) begin
                    base  = '0;
                    phase = PH_DONE;
                    r     = '0;
                    r.bad_radix = 1'b1;
                    due_results.push_back(r);
                    return;
                end
                base  = radix_reg;
                phase = PH_SPACE;
            end
            case (phase)
                PH_SPACE, PH_SIGNED: begin
                    if (phase == PH_SPACE && is_blank(c)) begin
                        // skip leading blanks
                    end else if (phase == PH_SPACE && (c == CH_PLUS || c == CH_MINUS)) begin
                        neg   = (c == CH_MINUS);
                        phase = PH_SIGNED;
                    end else if (c == CH_ZERO && (base == RADIX_AUTO || base == RADIX_HEX)) begin
                        phase = PH_ZERO;
                    end else begin
                        if (base == RADIX_AUTO)
                            base = RADIX_DEC;
                        stopped = digit_step(c, r);
                    end
                end
                PH_ZERO: begin
                    acc = '0;
                    if (c == CH_X) begin
                        base  = RADIX_HEX;
                        phase = PH_DIGITS;
                    end else begin
                        if (base == RADIX_AUTO)
                            base = RADIX_OCT;
                        stopped = digit_step(c, r);
                    end
                end
                PH_DIGITS: stopped = digit_step(c, r);
                default: return;
            endcase
            if (stopped)
                due_results.push_back(r);
            else if (pos < MAX_LEN_DEFAULT)
                pos++;
        endfunction

        // Compare one accepted result with the oldest expectation
        function void check_result(input uitp_result_t got);
            uitp_result_t want;
            if (due_results.size() == 0) begin
                $error("unexpected result: value %h stop_position %0d bad_radix %0d",
                       got.value, got.stop_position, got.bad_radix);
                n_fail++;
                return;
            end
            want = due_results.pop_front();
            n_checked++;
            if (got.value !== want.value) begin
                $error("value: expected %h, got %h", want.value, got.value);
                n_fail++;
            end
            if (got.stop_position !== want.stop_position) begin
                $error("stop_position: expected %0d, got %0d",
                       want.stop_position, got.stop_position);
                n_fail++;
            end
            if (got.bad_radix !== want.bad_radix) begin
                $error("bad_radix: expected %0d, got %0d", want.bad_radix, got.bad_radix);
                n_fail++;
            end
        endfunction

        function void check_drained();
            if (due_results.size() != 0) begin
                $error("%0d expected results never arrived", due_results.size());
                n_fail++;
            end
        endfunction
    endclass

    strtoul_scoreboard sb;

    bit                 tx_eager  = 1'b0;
    bit                 rx_eager  = 1'b0;
    bit                 hold_req  = 1'b0;
    int                 hold_left = 0;
    int                 rx_wait   = 0;
    int unsigned        cycle_count = 0;
    int unsigned        n_items   = 0;
    int unsigned        n_chars   = 0;
    int unsigned        n_strings = 0;
    int unsigned        n_writes  = 0;
    logic [RADIX_W-1:0] cur_radix = RADIX_RESET;

    always #CLK_HALF clk = ~clk;

    // Give up on a hung run
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Result side: sample transactions at the rising edge, drive ready at the falling edge
    always begin
        uitp_result_t got;
        @(posedge clk);
        if (rst_n && res_if.valid && res_if.ready) begin
            got.value         = res_if.value;
            got.stop_position = res_if.stop_position;
            got.bad_radix     = res_if.bad_radix;
            sb.check_result(got);
            rx_wait = rx_eager ? 0 : $urandom_range(0, MAX_GAP);
        end
        @(negedge clk);
        if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            res_if.ready <= 1'b0;
        end else if (rx_wait > 0) begin
            rx_wait--;
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= 1'b1;
        end
    end

    function automatic int next_gap();
        return tx_eager ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    // Offer one character; called and returns at a falling edge
    task automatic send_char(input logic [CHAR_W-1:0] c, input logic f, input int gap);
        if (gap > 0) begin
            item_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_if.valid <= 1'b1;
        item_if.ch    <= c;
        item_if.first <= f;
        do
            @(posedge clk);
        while (!item_if.ready);
        if (f || sb.busy())
            n_items++;
        if (f)
            n_strings++;
        n_chars++;
        sb.note_char(c, f);
        @(negedge clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], i == 0, next_gap());
    endtask

    // Drop valid, wait for every expected result, then let the pipeline empty
    task automatic settle();
        item_if.valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (SETTLE_LAT) @(negedge clk);
    endtask

    task automatic write_radix(input logic [RADIX_W-1:0] r);
        cfg_if.valid <= 1'b1;
        cfg_if.radix <= r;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        sb.set_radix(r);
        cur_radix = r;
        n_writes++;
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    function automatic logic [CHAR_W-1:0] digit_char(input int unsigned d);
        if (d < 10)
            return CH_ZERO + CHAR_W'(d);
        return ($urandom_range(0, 1) ? CH_LO_A : CH_UP_A) + CHAR_W'(d - 10);
    endfunction

    // One string: mostly well formed with random content, sometimes noise
    task automatic send_random_string();
        logic [CHAR_W-1:0] text_q[$];
        logic [CHAR_W-1:0] c;
        int unsigned       dbase;
        int unsigned       pick;
        string             dec_edge;
        dec_edge = "1844674407370955161";
        if ($urandom_range(0, 9) == 0) begin
            // noise with restart marks anywhere
            repeat ($urandom_range(1, 6))
                send_char(CHAR_W'($urandom_range(0, 255)), $urandom_range(0, 3) == 0,
                          next_gap());
            return;
        end
        repeat ($urandom_range(0, 2))
            text_q.push_back($urandom_range(0, 1) ? CH_SPACE
                                                  : CHAR_W'($urandom_range(CH_TAB, CH_CR)));
        pick = $urandom_range(0, 2);
        if (pick == 1)
            text_q.push_back(CH_PLUS);
        else if (pick == 2)
            text_q.push_back(CH_MINUS);
        if (cur_radix == RADIX_AUTO || cur_radix < RADIX_MIN || cur_radix > RADIX_MAX)
            dbase = 10;
        else
            dbase = cur_radix;
        pick = $urandom_range(0, 3);
        if (pick == 1) begin
            text_q.push_back(CH_ZERO);
            text_q.push_back(CH_X);
            if (cur_radix == RADIX_AUTO || cur_radix == RADIX_HEX)
                dbase = 16;
        end else if (pick == 2) begin
            text_q.push_back(CH_ZERO);
            if (cur_radix == RADIX_AUTO)
                dbase = 8;
        end
        // Digits: around the 64-bit limit, long enough to overflow, or short
        pick = $urandom_range(0, 7);
        if (pick == 0 && dbase == 10) begin
            for (int i = 0; i < dec_edge.len(); i++)
                text_q.push_back(dec_edge[i]);
            text_q.push_back(digit_char($urandom_range(0, 9)));
        end else if (pick == 1 && dbase == 16) begin
            repeat (16) text_q.push_back(digit_char(15));
            if ($urandom_range(0, 1))
                text_q.push_back(digit_char($urandom_range(0, 15)));
        end else begin
            repeat (pick == 2 ? $urandom_range(17, 70) : $urandom_range(0, 8))
                text_q.push_back(digit_char($urandom_range(0, dbase - 1)));
        end
        // Usually end on a non-digit; otherwise leave the string unfinished
        if ($urandom_range(0, 3) != 0) begin
            do
                c = CHAR_W'($urandom_range(0, 255));
            while (char_value(c) < dbase);
            text_q.push_back(c);
        end
        foreach (text_q[i])
            send_char(text_q[i], i == 0, next_gap());
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 2))
                send_char(CHAR_W'($urandom_range(0, 255)), 1'b0, next_gap());
    endtask

    initial begin
        int unsigned        item_goal;
        int unsigned        phase_end;
        int unsigned        phase_no;
        logic [RADIX_W-1:0] fixed_radix[8];
        sb = new();
        fixed_radix = '{RADIX_AUTO, RADIX_HEX, RADIX_MIN, RADIX_MAX, 6'd63, 6'd37,
                        RADIX_OCT, RADIX_DEC};
        rst_n         = 1'b0;
        item_if.valid = 1'b0;
        item_if.ch    = '0;
        item_if.first = 1'b0;
        cfg_if.valid  = 1'b0;
        cfg_if.radix  = '0;
        res_if.ready  = 1'b0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: reset radix, idle character, sign, byte extremes, unfinished string
        send_char(CH_UP_Z, 1'b0, next_gap());
        send_text(" -9;");
        send_char(8'hFF, 1'b1, next_gap());
        send_text("7");
        send_text("0x");
        settle();
        // Automatic base: hex prefix, octal, octal stopped by an 8
        write_radix(RADIX_AUTO);
        send_text("0x1F.");
        send_text("017 ");
        send_text("08");
        settle();
        // Invalid base, then a character that is dropped
        write_radix(RADIX_ONE);
        send_text("5");
        send_char(CH_ZERO + 8'd5, 1'b0, next_gap());
        settle();
        write_radix(RADIX_MAX);
        send_text("zZ?");

        // Random phases, each with its own radix and idling pattern
        item_goal = n_items + RANDOM_ITEMS;
        phase_no  = 0;
        while (n_items < item_goal) begin
            settle();
            if (phase_no < 8)
                write_radix(fixed_radix[phase_no]);
            else if ($urandom_range(0, 7) == 0)
                write_radix(RADIX_W'($urandom_range(0, 63)));
            else if ($urandom_range(0, 5) == 0)
                write_radix(RADIX_AUTO);
            else
                write_radix(RADIX_W'($urandom_range(RADIX_MIN, RADIX_MAX)));
            tx_eager = ($urandom_range(0, 3) == 0);
            rx_eager = ($urandom_range(0, 3) == 0);
            // Stall the result side for a long stretch while characters keep coming
            if (phase_no == 1) begin
                tx_eager = 1'b1;
                hold_req = 1'b1;
            end
            phase_end = n_items + $urandom_range(25, 50);
            while (n_items < phase_end)
                send_random_string();
            phase_no++;
        end

        // One long negative string: saturated value kept as all ones
        settle();
        write_radix(RADIX_DEC);
        tx_eager = 1'b1;
        send_char(CH_MINUS, 1'b1, 0);
        repeat (LONG_DIGITS) send_char(CH_NINE, 1'b0, 0);
        send_char(8'h2E, 1'b0, 0);

        settle();
        sb.check_drained();
        $display("Run covered %0d strings, %0d characters and %0d radix writes;",
                 n_strings, n_chars, n_writes);
        $display("%0d results compared, %0d mismatches.", sb.n_checked, sb.n_fail);
        if (sb.n_fail == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

[sim.f]
src/uitp_pkg.sv
src/uitp_ifs.sv
src/uitp_in_reg.sv
src/uitp_core.sv
src/uitp_out_reg.sv
src/unsigned_integer_text_parser_top.sv
src/uitp_checker.sv
dv/tb_unsigned_integer_text_parser_top.sv
